/* src/assert_macros.svh */
// Assertion macros shared by the mixer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is skipped while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/smsc_pkg.sv */
// Shared constants and codes for the stem mixer with soft clipper.
// No dependencies; used by smsc_bus_clip and the top level.
`timescale 1ns / 1ps
`default_nettype none

package smsc_pkg;

  localparam int SMSC_NUM_STEMS      = 4;
  localparam int SMSC_SAMPLE_BITS    = 16;
  localparam int SMSC_GAIN_FRAC_BITS = 14;

  localparam int GAIN_W    = 16;
  localparam int POS_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAIN_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUE_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_SIDES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_PLAY  = 3'd1,
    KIND_PAUSE = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_SEEK  = 3'd4
  } kind_e;

endpackage

`default_nettype wire

/* src/stem_mixer_soft_clip_transport.sv */
// Stem mixer with soft clipper and transport: top level, uses smsc_pkg and smsc_bus_clip.
// Frame tick while playing: the stems are summed into the main bus, then both bus lanes run
// in parallel through the serial gain multiply and, when a bus enters the clipper, the
// restoring divider; the emit state then loads the output word once the output is free.
// Other items go from accept straight to emit. One item in flight at a time.
// Reset (async, active low) clears transport state, loads register defaults, empties output.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stem_mixer_soft_clip_transport #(
  parameter int NUM_STEMS      = smsc_pkg::SMSC_NUM_STEMS,
  parameter int SAMPLE_BITS    = smsc_pkg::SMSC_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = smsc_pkg::SMSC_GAIN_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [smsc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [smsc_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // stem_a .. stem_(NUM_STEMS), click_sample, seek_target, zero fill
  input  logic [(((NUM_STEMS+1)*SAMPLE_BITS+smsc_pkg::POS_W+7)/8)*8-1:0] s_axis_tdata_i,
  // kind
  input  logic [smsc_pkg::KIND_W-1:0]            s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // left_out, right_out, frame_position, is_playing, reached_end, zero fill
  output logic [((2*SAMPLE_BITS+smsc_pkg::POS_W+2+7)/8)*8-1:0] m_axis_tdata_o
);
  import smsc_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(NUM_STEMS);
  localparam int OUT_W  = ((2 * SAMPLE_BITS + POS_W + 2 + 7) / 8) * 8;
  localparam int STEM_W = NUM_STEMS * SAMPLE_BITS;
  localparam int SCNT_W = $clog2(NUM_STEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_START,
    S_WAIT,
    S_EMIT
  } top_state_e;

  // configuration
  logic [GAIN_W-1:0] main_gain_q;
  logic [GAIN_W-1:0] cue_gain_q;
  logic              swap_q;
  logic [POS_W-1:0]  song_len_q;

  // transport
  logic [POS_W-1:0]  pos_q;
  logic              run_q;
  logic              done_q;
  logic [POS_W-1:0]  pos_nx;
  logic              run_nx;
  logic              done_nx;
  logic [POS_W:0]    pos_inc;
  logic [POS_W-1:0]  seek_t;

  top_state_e               state_q;
  logic [STEM_W-1:0]        stems_q;
  logic [SB-1:0]            click_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SCNT_W-1:0]        scnt_q;
  logic signed [SB-1:0]     pend_left_q;
  logic signed [SB-1:0]     pend_right_q;
  logic [POS_W-1:0]         pend_pos_q;
  logic                     pend_play_q;
  logic                     pend_end_q;
  logic                     m_valid_q;
  logic [OUT_W-1:0]         m_data_q;

  logic                     in_acc;
  logic                     lane_start;
  logic                     main_busy;
  logic                     cue_busy;
  logic signed [SB-1:0]     main_sample;
  logic signed [SB-1:0]     cue_sample;
  logic signed [SUM_W-1:0]  cue_value;

  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign lane_start = (state_q == S_START);
  assign cue_value  = SUM_W'($signed(click_q));
  assign seek_t     = s_axis_tdata_i[(NUM_STEMS+1)*SB +: POS_W];
  assign pos_inc    = {1'b0, pos_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_gain_q <= GAIN_UNITY;
      cue_gain_q  <= GAIN_UNITY;
      swap_q      <= 1'b0;
      song_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAIN_GAIN:   main_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_CUE_GAIN:    cue_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_SWAP_SIDES:  swap_q      <= cfg_data_i[0];
        REG_SONG_LENGTH: song_len_q  <= cfg_data_i[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // transport state after the item at the input
  always_comb begin
    pos_nx  = pos_q;
    run_nx  = run_q;
    done_nx = done_q;
    case (kind_e'(s_axis_tuser_i))
      KIND_TICK: begin
        if (run_q) begin
          if (pos_inc >= {1'b0, song_len_q}) begin
            pos_nx  = song_len_q;
            run_nx  = 1'b0;
            done_nx = 1'b1;
          end else begin
            pos_nx = pos_inc[POS_W-1:0];
          end
        end
      end
      KIND_PLAY: begin
        run_nx  = 1'b1;
        done_nx = 1'b0;
      end
      KIND_PAUSE: begin
        run_nx = 1'b0;
      end
      KIND_STOP: begin
        run_nx  = 1'b0;
        pos_nx  = '0;
        done_nx = 1'b0;
      end
      KIND_SEEK: begin
        pos_nx  = (seek_t > song_len_q) ? song_len_q : seek_t;
        done_nx = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pos_q        <= '0;
      run_q        <= 1'b0;
      done_q       <= 1'b0;
      stems_q      <= '0;
      click_q      <= '0;
      sum_q        <= '0;
      scnt_q       <= '0;
      pend_left_q  <= '0;
      pend_right_q <= '0;
      pend_pos_q   <= '0;
      pend_play_q  <= 1'b0;
      pend_end_q   <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      // drop the output word once taken, unless emit reloads it
      if (m_valid_q && m_axis_tready_i && (state_q != S_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pos_q        <= pos_nx;
            run_q        <= run_nx;
            done_q       <= done_nx;
            pend_pos_q   <= pos_nx;
            pend_play_q  <= run_nx;
            pend_end_q   <= done_nx;
            pend_left_q  <= '0;
            pend_right_q <= '0;
            stems_q      <= s_axis_tdata_i[STEM_W-1:0];
            click_q      <= s_axis_tdata_i[STEM_W +: SB];
            sum_q        <= '0;
            scnt_q       <= SCNT_W'(NUM_STEMS);
            if ((kind_e'(s_axis_tuser_i) == KIND_TICK) && run_q) begin
              state_q <= S_SUM;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end
        S_SUM: begin
          // one stem per cycle out of the shift register
          sum_q   <= sum_q + SUM_W'($signed(stems_q[SB-1:0]));
          stems_q <= stems_q >> SB;
          scnt_q  <= scnt_q - 1'b1;
          if (scnt_q == SCNT_W'(1)) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!main_busy && !cue_busy) begin
            pend_left_q  <= swap_q ? cue_sample : main_sample;
            pend_right_q <= swap_q ? main_sample : cue_sample;
            state_q      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_W'({pend_end_q, pend_play_q, pend_pos_q,
                                 pend_right_q, pend_left_q});
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  smsc_bus_clip #(
    .NUM_STEMS      (NUM_STEMS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_main_bus (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .value_i  (sum_q),
    .gain_i   (main_gain_q),
    .busy_o   (main_busy),
    .sample_o (main_sample)
  );

  smsc_bus_clip #(
    .NUM_STEMS      (NUM_STEMS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_cue_bus (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .value_i  (cue_value),
    .gain_i   (cue_gain_q),
    .busy_o   (cue_busy),
    .sample_o (cue_sample)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `ASSERT_ALWAYS(a_run_done_excl, clk_i, !(run_q && done_q), "playing and finished at once")
  `ASSERT_RST(a_lane_in_wait, clk_i, rst_ni, (main_busy || cue_busy) |-> (state_q == S_WAIT), "bus lane busy outside wait")
  `ASSERT_RST(a_valid_from_emit, clk_i, rst_ni, $rose(m_valid_q) |-> ($past(state_q) == S_EMIT), "output word not from emit")
  `ASSERT_RST(a_tick_blocks, clk_i, rst_ni, (in_acc && (s_axis_tuser_i == KIND_TICK) && run_q) |=> !s_axis_tready_o, "ready during audio frame")

endmodule

`default_nettype wire

/* src/smsc_bus_clip.sv */
// One bus lane: serial gain multiply, rounding or rational soft clip, saturation.
// Depends on smsc_pkg; instantiated twice by stem_mixer_soft_clip_transport.
`timescale 1ns / 1ps
`default_nettype none

module smsc_bus_clip #(
  parameter int NUM_STEMS      = smsc_pkg::SMSC_NUM_STEMS,
  parameter int SAMPLE_BITS    = smsc_pkg::SMSC_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = smsc_pkg::SMSC_GAIN_FRAC_BITS
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               start_i,
  input  logic signed [SAMPLE_BITS+$clog2(NUM_STEMS)-1:0]    value_i,
  input  logic        [smsc_pkg::GAIN_W-1:0]                 gain_i,
  output logic                                               busy_o,
  output logic signed [SAMPLE_BITS-1:0]                      sample_o
);
  import smsc_pkg::*;

  localparam int S      = SAMPLE_BITS - 1;
  localparam int G      = GAIN_FRAC_BITS;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(NUM_STEMS);
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int DW     = PROD_W + 1;
  localparam int Q_W    = SAMPLE_BITS;
  localparam int NB     = 2 * S + G;
  localparam int NUM_W  = ((NB > DW) ? NB : DW) + 1;
  localparam int CNT_MAX = (GAIN_W > Q_W) ? GAIN_W : Q_W;
  localparam int CNT_W  = $clog2(CNT_MAX + 1);

  localparam logic [PROD_W-1:0] ONE_X    = {{(PROD_W-1){1'b0}}, 1'b1} << (S + G);
  localparam logic [PROD_W:0]   HALF     = {{PROD_W{1'b0}}, 1'b1} << (G - 1);
  localparam logic [PROD_W:0]   SMAX_W   = ({{PROD_W{1'b0}}, 1'b1} << S) - 1'b1;
  localparam logic [S-1:0]      SMAX_S   = '1;
  localparam logic [S:0]        ONE_S    = {1'b1, {S{1'b0}}};
  localparam logic [NUM_W-1:0]  NUM_BASE = {{(NUM_W-1){1'b0}}, 1'b1} << NB;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_CHK,
    L_PREP,
    L_DIV,
    L_FIN
  } lane_state_e;

  lane_state_e        state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q;
  logic [PROD_W-1:0]  mcand_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [PROD_W-1:0]  acc_q;
  logic [DW-1:0]      d_q;
  logic [DW-1:0]      rem_q;
  logic [Q_W-1:0]     qsh_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic [SUM_W-1:0]   mag_in;
  logic [PROD_W-1:0]  acc_d;
  logic [PROD_W:0]    rnd;
  logic [S-1:0]       rnd_mag;
  logic [DW-1:0]      d_init;
  logic [NUM_W-1:0]   num_sum;
  logic [DW:0]        div_t;
  logic               div_ge;
  logic [DW-1:0]      rem_d;
  logic [S:0]         q_diff;
  logic [S-1:0]       q_mag;

  function automatic logic signed [SAMPLE_BITS-1:0] with_sign(input logic n,
                                                              input logic [S-1:0] m);
    logic [SAMPLE_BITS-1:0] v;
    v = {1'b0, m};
    return n ? -v : v;
  endfunction

  always_comb begin
    mag_in  = value_i[SUM_W-1] ? SUM_W'(-value_i) : SUM_W'(value_i);
    acc_d   = acc_q + (gain_q[0] ? mcand_q : '0);
    // round half up, then clamp to the largest positive magnitude
    rnd     = ({1'b0, acc_q} + HALF) >> G;
    rnd_mag = (rnd > SMAX_W) ? SMAX_S : rnd[S-1:0];
    d_init  = {acc_q, 1'b0} - {1'b0, ONE_X};
    num_sum = NUM_BASE + NUM_W'(d_q >> 1);
    // restoring divide step: shift in the next dividend bit, subtract if it fits
    div_t   = {rem_q, qsh_q[Q_W-1]};
    div_ge  = div_t >= {1'b0, d_q};
    rem_d   = div_ge ? DW'(div_t - {1'b0, d_q}) : div_t[DW-1:0];
    q_diff  = ONE_S - qsh_q;
    q_mag   = (qsh_q == '0) ? SMAX_S : q_diff[S-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      mcand_q  <= '0;
      gain_q   <= '0;
      acc_q    <= '0;
      d_q      <= '0;
      rem_q    <= '0;
      qsh_q    <= '0;
      sample_q <= '0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            neg_q   <= value_i[SUM_W-1];
            mcand_q <= PROD_W'(mag_in);
            gain_q  <= gain_i;
            acc_q   <= '0;
            cnt_q   <= CNT_W'(GAIN_W);
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          acc_q   <= acc_d;
          mcand_q <= mcand_q << 1;
          gain_q  <= gain_q >> 1;
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= L_CHK;
          end
        end
        L_CHK: begin
          if (acc_q <= ONE_X) begin
            sample_q <= with_sign(neg_q, rnd_mag);
            state_q  <= L_IDLE;
          end else begin
            d_q     <= d_init;
            state_q <= L_PREP;
          end
        end
        L_PREP: begin
          // upper dividend bits are already below the divisor
          rem_q   <= DW'(num_sum >> Q_W);
          qsh_q   <= num_sum[Q_W-1:0];
          cnt_q   <= CNT_W'(Q_W);
          state_q <= L_DIV;
        end
        L_DIV: begin
          rem_q   <= rem_d;
          qsh_q   <= {qsh_q[Q_W-2:0], div_ge};
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= L_FIN;
          end
        end
        L_FIN: begin
          sample_q <= with_sign(neg_q, q_mag);
          state_q  <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != L_IDLE);
  assign sample_o = sample_q;

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for stem_mixer_soft_clip_transport: transport commands, bus mixing and
// the soft clipper, with random stalls on both stream sides. Uses smsc_pkg for widths and codes.

module testbench;
  import smsc_pkg::*;

  localparam int S_W         = SMSC_SAMPLE_BITS;
  localparam int G_W         = SMSC_GAIN_FRAC_BITS;
  localparam int S_DATA_W    = (((SMSC_NUM_STEMS + 1) * S_W + POS_W + 7) / 8) * 8;
  localparam int M_DATA_W    = ((2 * S_W + POS_W + 2 + 7) / 8) * 8;
  localparam int SEEK_LSB    = (SMSC_NUM_STEMS + 1) * S_W;
  localparam int POS_LSB     = 2 * S_W;
  localparam int MAX_WAIT    = 12;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 218;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SHOW_ERRORS = 10;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam longint ONE_X    = longint'(1) << (S_W - 1 + G_W);
  localparam longint CLIP_NUM = longint'(1) << (2 * (S_W - 1) + G_W);
  localparam longint HALF_LSB = longint'(1) << (G_W - 1);
  localparam longint SMAX     = (longint'(1) << (S_W - 1)) - 1;
  localparam longint SMIN     = -(longint'(1) << (S_W - 1));

  typedef struct {
    logic signed [S_W-1:0] left;
    logic signed [S_W-1:0] right;
    logic [POS_W-1:0]      pos;
    logic                  playing;
    logic                  at_end;
  } mix_result_t;

  class mix_scoreboard;
    logic [GAIN_W-1:0] main_gain;
    logic [GAIN_W-1:0] cue_gain;
    logic              swap_sides;
    logic [POS_W-1:0]  song_len;
    logic [POS_W-1:0]  position;
    logic              running;
    logic              finished;
    mix_result_t       expected_q[$];
    int                errors;
    int                checked;
    int                audio_frames;
    int                clipped_samples;
    int                song_ends;

    function new();
      main_gain       = GAIN_UNITY;
      cue_gain        = GAIN_UNITY;
      swap_sides      = 1'b0;
      song_len        = '0;
      position        = '0;
      running         = 1'b0;
      finished        = 1'b0;
      errors          = 0;
      checked         = 0;
      audio_frames    = 0;
      clipped_samples = 0;
      song_ends       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_MAIN_GAIN:   main_gain = value[GAIN_W-1:0];
        REG_CUE_GAIN:    cue_gain = value[GAIN_W-1:0];
        REG_SWAP_SIDES:  swap_sides = value[0];
        REG_SONG_LENGTH: song_len = value[POS_W-1:0];
        default: ;
      endcase
    endfunction

    // Positive half of the clipper: rounding below one, 1 - 1/(2x-1) above it.
    function longint shape_mag(longint mag);
      longint o;
      longint d;
      longint q;
      if (mag <= ONE_X) begin
        o = (mag + HALF_LSB) >>> G_W;
      end else begin
        clipped_samples++;
        d = 2 * mag - ONE_X;
        q = (CLIP_NUM + d / 2) / d;
        o = SMAX + 1 - q;
      end
      if (o > SMAX) o = SMAX;
      if (o < SMIN) o = SMIN;
      return o;
    endfunction

    function logic [S_W-1:0] shape_bus(longint x);
      longint o;
      if (x < 0) begin
        o = -shape_mag(-x);
        if (o < SMIN) o = SMIN;
      end else begin
        o = shape_mag(x);
      end
      return o[S_W-1:0];
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
      mix_result_t      r;
      longint           sum;
      logic [S_W-1:0]   main_s;
      logic [S_W-1:0]   cue_s;
      logic [POS_W:0]   nxt;
      logic [POS_W-1:0] target;
      r.left  = '0;
      r.right = '0;
      case (kind)
        KIND_TICK: begin
          if (running) begin
            sum = 0;
            for (int i = 0; i < SMSC_NUM_STEMS; i++)
              sum += longint'($signed(data[i*S_W +: S_W]));
            main_s = shape_bus(sum * longint'(main_gain));
            cue_s  = shape_bus(longint'($signed(data[SMSC_NUM_STEMS*S_W +: S_W]))
                               * longint'(cue_gain));
            r.left  = swap_sides ? cue_s : main_s;
            r.right = swap_sides ? main_s : cue_s;
            audio_frames++;
            nxt = {1'b0, position} + 1'b1;
            if (nxt >= {1'b0, song_len}) begin
              position = song_len;
              running  = 1'b0;
              finished = 1'b1;
              song_ends++;
            end else begin
              position = nxt[POS_W-1:0];
            end
          end
        end
        KIND_PLAY: begin
          finished = 1'b0;
          running  = 1'b1;
        end
        KIND_PAUSE: running = 1'b0;
        KIND_STOP: begin
          running  = 1'b0;
          finished = 1'b0;
          position = '0;
        end
        KIND_SEEK: begin
          target   = data[SEEK_LSB +: POS_W];
          position = (target > song_len) ? song_len : target;
          finished = 1'b0;
        end
        default: ;
      endcase
      r.pos     = position;
      r.playing = running;
      r.at_end  = finished;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [M_DATA_W-1:0] word);
      mix_result_t e;
      mix_result_t got;
      got.left    = word[0 +: S_W];
      got.right   = word[S_W +: S_W];
      got.pos     = word[POS_LSB +: POS_W];
      got.playing = word[POS_LSB + POS_W];
      got.at_end  = word[POS_LSB + POS_W + 1];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS) $display("output word %h with nothing expected", word);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.left !== e.left || got.right !== e.right || got.pos !== e.pos ||
          got.playing !== e.playing || got.at_end !== e.at_end) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("mismatch: exp L %0d R %0d pos %0d play %0b end %0b / got L %0d R %0d pos %0d play %0b end %0b",
                   e.left, e.right, e.pos, e.playing, e.at_end,
                   got.left, got.right, got.pos, got.playing, got.at_end);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_DATA_W-1:0]  s_axis_tdata_i;
  logic [KIND_W-1:0]    s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_DATA_W-1:0]  m_axis_tdata_o;

  mix_scoreboard sb = new();
  logic          send_idle = 1'b1;
  logic          recv_idle = 1'b1;
  int            sent_words = 0;
  int            settings = 0;
  int            cycles = 0;

  stem_mixer_soft_clip_transport dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Output side: stall a random number of cycles, then take one word.
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o);
    end
  end

  function automatic logic [S_DATA_W-1:0] pack_frame(logic [S_W-1:0] a, logic [S_W-1:0] b,
                                                     logic [S_W-1:0] c, logic [S_W-1:0] d,
                                                     logic [S_W-1:0] click,
                                                     logic [POS_W-1:0] seek);
    return S_DATA_W'({seek, click, d, c, b, a});
  endfunction

  function automatic logic [S_W-1:0] any_sample();
    return S_W'($urandom);
  endfunction

  function automatic logic [S_W-1:0] corner_sample();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  task automatic send_word(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] data);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(kind, data);
    sent_words++;
  endtask

  task automatic tick(logic [S_W-1:0] a, logic [S_W-1:0] b, logic [S_W-1:0] c,
                      logic [S_W-1:0] d, logic [S_W-1:0] click);
    send_word(KIND_TICK, pack_frame(a, b, c, d, click, $urandom));
  endtask

  task automatic command(logic [KIND_W-1:0] kind, logic [POS_W-1:0] seek);
    send_word(kind, pack_frame(any_sample(), any_sample(), any_sample(), any_sample(),
                               any_sample(), seek));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  // Drop valid and hold until every expected word is back.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic [GAIN_W-1:0] mg, logic [GAIN_W-1:0] cg, logic sw,
                           logic [POS_W-1:0] len);
    write_reg(REG_MAIN_GAIN, {16'($urandom), mg});
    write_reg(REG_CUE_GAIN, {16'($urandom), cg});
    write_reg(REG_SWAP_SIDES, {31'($urandom), sw});
    write_reg(REG_SONG_LENGTH, len);
    settings++;
  endtask

  function automatic logic [POS_W-1:0] pick_seek();
    longint t;
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: begin
        t = longint'(sb.song_len) + $urandom_range(0, 6) - 3;
        if (t < 0) t = 0;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        return t[POS_W-1:0];
      end
      default: return $urandom_range(0, sb.song_len);
    endcase
  endfunction

  // Bus sum that lands near the clipper knee for the given gain.
  function automatic longint knee_sum(logic [GAIN_W-1:0] gain, longint cap);
    longint thr;
    thr = (gain == 0) ? cap : ONE_X / longint'(gain);
    if (thr > cap) thr = cap;
    thr = thr + $urandom_range(0, 80) - 40;
    return $urandom_range(0, 1) ? thr : -thr;
  endfunction

  function automatic logic [KIND_W-1:0] KIND_KIND_SPARE();
    return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
  endfunction

  task automatic random_item();
    int               r;
    logic [KIND_W-1:0] kind;
    logic [S_W-1:0]   st[4];
    logic [S_W-1:0]   click;
    longint           target;
    longint           q;
    r = $urandom_range(0, 99);
    if (r < 62) kind = KIND_TICK;
    else if (r < 76) kind = KIND_PLAY;
    else if (r < 81) kind = KIND_PAUSE;
    else if (r < 85) kind = KIND_STOP;
    else if (r < 95) kind = KIND_SEEK;
    else kind = KIND_KIND_SPARE();
    case ($urandom_range(0, 3))
      0: begin
        foreach (st[i]) st[i] = any_sample();
        click = any_sample();
      end
      1: begin
        foreach (st[i]) st[i] = S_W'(int'($urandom_range(0, 3000)) - 1500);
        click = S_W'(int'($urandom_range(0, 3000)) - 1500);
      end
      2: begin
        target = knee_sum(sb.main_gain, 120000);
        q = target / 4;
        for (int i = 0; i < 3; i++) st[i] = S_W'(q + $urandom_range(0, 600) - 300);
        st[3] = S_W'(target - longint'($signed(st[0])) - longint'($signed(st[1]))
                     - longint'($signed(st[2])));
        click = S_W'(knee_sum(sb.cue_gain, 32000));
      end
      default: begin
        foreach (st[i]) st[i] = corner_sample();
        click = corner_sample();
      end
    endcase
    send_word(kind, pack_frame(st[0], st[1], st[2], st[3], click, pick_seek()));
  endtask

  initial begin
    int start;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_TICK;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults, zero song length: every tick ends the song at once.
    tick(any_sample(), any_sample(), any_sample(), any_sample(), any_sample());
    command(KIND_PLAY, $urandom);
    tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    command(KIND_SPARE_LO, $urandom);
    command(KIND_SPARE_HI, $urandom);
    command(KIND_SEEK, 32'hFFFF_FFFF);
    command(KIND_PAUSE, $urandom);
    command(KIND_STOP, $urandom);
    settle();

    configure(GAIN_UNITY, GAIN_UNITY, 1'b1, 32'd20);
    command(KIND_PLAY, $urandom);
    tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    tick(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    tick(16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h8000);
    tick(16'hE000, 16'hE000, 16'hE000, 16'hE000, 16'h7FFF);
    tick(16'h2001, 16'h2000, 16'h2000, 16'h2000, 16'h0001);
    tick(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    command(KIND_SEEK, 32'hFFFF_FFFF);
    command(KIND_SEEK, 32'd18);
    tick(any_sample(), any_sample(), any_sample(), any_sample(), any_sample());
    tick(any_sample(), any_sample(), any_sample(), any_sample(), any_sample());
    tick(any_sample(), any_sample(), any_sample(), any_sample(), any_sample());
    command(KIND_PLAY, $urandom);
    tick(any_sample(), any_sample(), any_sample(), any_sample(), any_sample());
    command(KIND_STOP, $urandom);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(GAIN_UNITY, GAIN_UNITY, 1'b0, $urandom_range(20, 80));
        1: configure('0, 16'hFFFF, 1'b1, $urandom_range(1, 40));
        2: configure(16'hFFFF, '0, 1'b0, 32'hFFFF_FFFF);
        3: configure(GAIN_W'($urandom), GAIN_W'($urandom), 1'($urandom), '0);
        4: configure(GAIN_W'($urandom_range(1, 16383)), GAIN_W'($urandom_range(1, 16383)),
                     1'b1, $urandom);
        5: configure(GAIN_W'($urandom), GAIN_W'($urandom), 1'($urandom), 32'd1);
        default: configure(GAIN_W'($urandom), GAIN_W'($urandom), 1'($urandom),
                           $urandom_range(2, 200));
      endcase
      // Some phases run back to back with no gaps on one or both sides.
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
      start = sent_words;
      while (sent_words - start < PHASE_WORDS) random_item();
      settle();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("tb: %0d words checked, %0d audio frames, %0d bus samples in the clipper",
             sb.checked, sb.audio_frames, sb.clipped_samples);
    $display("tb: %0d song ends over %0d register settings, %0d errors",
             sb.song_ends, settings, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
